>>> src/dqsm_pkg.sv
// Shared types and constants of the distributed queueing station MAC.
package dqsm_pkg;

  // Minislots per frame; at most three carry outcomes on the input item.
  localparam int MINISLOTS  = 3;
  localparam int SLOTS_USED = (MINISLOTS < 3) ? MINISLOTS : 3;
  localparam int SLOT_PORTS = 3;

  // Defaults for the top-level parameters.
  localparam int TQ_DEPTH  = 64;
  localparam int SIZE_BITS = 8;

  // Packet-count storage is split into banks by the low pointer bits, so the up to
  // three entries appended by one feedback item always land in distinct banks.
  localparam int TQ_BANK_W = 2;
  localparam int TQ_BANKS  = 1 << TQ_BANK_W;

  // Collision resolution queue length saturates here.
  localparam logic [7:0] RQ_MAX = 8'd255;

  // Width of the input tdata bus: 41 payload bits padded to whole bytes.
  localparam int IN_DATA_W = 48;

  // Item kinds carried in tuser.
  localparam logic REQ_FRAME_START = 1'b0;
  localparam logic REQ_FEEDBACK    = 1'b1;

  // Minislot outcome codes; the code above collision also counts as a collision.
  localparam logic [1:0] SLOT_EMPTY     = 2'd0;
  localparam logic [1:0] SLOT_SUCCESS   = 2'd1;
  localparam logic [1:0] SLOT_COLLISION = 2'd2;

  typedef struct packed {
    logic                       req_type;
    logic                       has_message;
    logic [7:0]                 message_size;
    logic [1:0]                 chosen_slot;
    logic [SLOT_PORTS-1:0][1:0] slot_state;
    logic [SLOT_PORTS-1:0][7:0] slot_size;
  } in_item_t;

endpackage

>>> src/distributed_queue_station_mac_unit.sv
// Medium-access unit of one station in a distributed-queueing random-access protocol.
// Pipeline: input register, then result register, between input transaction and result.
// One transaction per cycle unless the output stalls; all work for an item is one pass of logic.
// Queued packet counts sit in four banks of the small RAM below; the head count is a register.
// Reset: queue lengths, pointers, own positions, request flag and own slot clear; RAM undefined.
// Both pipeline registers come out of reset empty.
module distributed_queue_station_mac_unit #(
  parameter int  TqDepth  = dqsm_pkg::TQ_DEPTH,   // 4 .. 1024 entries
  parameter int  SizeBits = dqsm_pkg::SIZE_BITS,  // 4 .. 16 bits per packet count
  localparam int CntW     = $clog2(TqDepth + 1),
  localparam int PtrW     = (TqDepth > 8) ? $clog2(TqDepth) : 3,
  localparam int RowW     = PtrW - dqsm_pkg::TQ_BANK_W,
  localparam int OutBits  = 29 + 2 * CntW,
  localparam int OutDataW = ((OutBits + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // has_message, message_size[8], chosen_slot[2], slot_state_1[2], slot_state_2[2],
  // slot_state_3[2], slot_size_1[8], slot_size_2[8], slot_size_3[8], zero pad
  input  logic [dqsm_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // req_type
  input  logic                           s_axis_tuser,
  // Result stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // send_data, send_request, request_slot[2], request_size[8], tq_length[CntW],
  // rq_length[8], tq_position[CntW], rq_position[8], overflow, zero pad
  output logic [OutDataW-1:0]            m_axis_tdata
);
  import dqsm_pkg::*;

  // ---------------------------------------------------------------------------
  // Pipeline control: advance when the result register is empty or being drained.
  // ---------------------------------------------------------------------------
  logic     advance;
  logic     item_valid_q;
  logic     out_valid_q;
  in_item_t item_q;
  in_item_t in_item;
  logic     [OutDataW-1:0] out_data_q;
  logic     [OutBits-1:0]  result;
  logic     step;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !item_valid_q || advance;
  assign step          = advance && item_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Unpack the incoming transaction, lowest field first.
  always_comb begin
    in_item.req_type      = s_axis_tuser;
    in_item.has_message   = s_axis_tdata[0];
    in_item.message_size  = s_axis_tdata[8:1];
    in_item.chosen_slot   = s_axis_tdata[10:9];
    in_item.slot_state[0] = s_axis_tdata[12:11];
    in_item.slot_state[1] = s_axis_tdata[14:13];
    in_item.slot_state[2] = s_axis_tdata[16:15];
    in_item.slot_size[0]  = s_axis_tdata[24:17];
    in_item.slot_size[1]  = s_axis_tdata[32:25];
    in_item.slot_size[2]  = s_axis_tdata[40:33];
  end

  // ---------------------------------------------------------------------------
  // Station state.
  // ---------------------------------------------------------------------------
  logic [CntW-1:0] tq_count_q, tq_count_d;
  logic [7:0]      rq_count_q, rq_count_d;
  logic [CntW-1:0] own_tq_pos_q, own_tq_pos_d;
  logic [7:0]      own_rq_pos_q, own_rq_pos_d;
  logic            req_flag_q, req_flag_d;
  logic [1:0]      own_slot_q, own_slot_d;

  // Ring pointers into the banked packet-count store. The head message's remaining
  // count is either held in head_val_q or, right after a pop, waits in the read data
  // register of the bank that holds the new head.
  logic [PtrW-1:0]     head_ptr_q, head_ptr_d;
  logic [PtrW-1:0]     tail_ptr_q, tail_ptr_d;
  logic [SizeBits-1:0] head_val_q, head_val_d;
  logic                head_ram_q, head_ram_d;

  // Bank ports.
  logic [TQ_BANKS-1:0]                bank_we;
  logic [TQ_BANKS-1:0]                bank_re;
  logic [TQ_BANKS-1:0][RowW-1:0]      bank_waddr;
  logic [TQ_BANKS-1:0][SizeBits-1:0]  bank_wdata;
  logic [TQ_BANKS-1:0][SizeBits-1:0]  bank_rdata;
  logic [RowW-1:0]                    rd_row;

  // Per-item working signals.
  logic                               send_data, send_request;
  logic [1:0]                         req_slot;
  logic [7:0]                         req_size;
  logic                               overflow;
  logic                               is_feedback;
  logic                               pop;
  logic [SizeBits-1:0]                head_cur;
  logic [SizeBits-1:0]                head_dec;
  logic [CntW-1:0]                    tq_fill;
  logic [PtrW-1:0]                    push_ptr;
  logic                               any_push;
  logic [SizeBits-1:0]                first_sz;
  logic                               mine;
  logic                               own_succ, own_coll, own_drop;
  logic [1:0]                         ncoll, coll_rank;
  logic [7:0]                         rq_dec;
  logic [8:0]                         rq_sum, rq_pos;

  assign is_feedback = (item_q.req_type == REQ_FEEDBACK);
  assign head_cur    = head_ram_q ? bank_rdata[head_ptr_q[TQ_BANK_W-1:0]] : head_val_q;

  always_comb begin
    send_data    = 1'b0;
    send_request = 1'b0;
    req_slot     = 2'd0;
    req_size     = 8'd0;
    overflow     = 1'b0;
    tq_count_d   = tq_count_q;
    rq_count_d   = rq_count_q;
    own_tq_pos_d = own_tq_pos_q;
    own_rq_pos_d = own_rq_pos_q;
    req_flag_d   = req_flag_q;
    own_slot_d   = own_slot_q;
    head_ptr_d   = head_ptr_q;
    tail_ptr_d   = tail_ptr_q;
    head_val_d   = head_val_q;
    head_ram_d   = head_ram_q;
    bank_we      = '0;
    bank_re      = '0;
    bank_waddr   = '0;
    bank_wdata   = '0;
    rd_row       = '0;
    pop          = 1'b0;
    head_dec     = head_cur;
    tq_fill      = tq_count_q;
    push_ptr     = tail_ptr_q;
    any_push     = 1'b0;
    first_sz     = '0;
    mine         = 1'b0;
    own_succ     = 1'b0;
    own_coll     = 1'b0;
    own_drop     = 1'b0;
    ncoll        = 2'd0;
    coll_rank    = 2'd0;
    rq_dec       = rq_count_q;
    rq_sum       = 9'd0;
    rq_pos       = 9'd0;

    if (!is_feedback) begin
      // Frame start: decide data and request transmissions.
      send_data = (tq_count_q != '0) && (own_tq_pos_q == CntW'(1));
      send_request = ((rq_count_q == 8'd0) && (own_tq_pos_q == '0) &&
                      (own_rq_pos_q == 8'd0) && item_q.has_message) ||
                     ((rq_count_q != 8'd0) && (own_rq_pos_q == 8'd1));
      if (send_request) begin
        // Clamp the chosen minislot into the range in use.
        req_slot = item_q.chosen_slot;
        if (req_slot == 2'd0) req_slot = 2'd1;
        if (req_slot > 2'(SLOTS_USED)) req_slot = 2'(SLOTS_USED);
        req_size = 8'(SizeBits'(item_q.message_size));
      end
      req_flag_d = send_request;
      own_slot_d = req_slot;
    end else begin
      // Head message loses one packet; drop it from the queue once finished.
      if (tq_count_q != '0) begin
        if (head_cur != '0) head_dec = head_cur - SizeBits'(1);
        if (head_dec == '0) begin
          pop        = 1'b1;
          tq_fill    = tq_count_q - CntW'(1);
          head_ptr_d = head_ptr_q + PtrW'(1);
          if (own_tq_pos_q != '0) own_tq_pos_d = own_tq_pos_q - CntW'(1);
        end else begin
          head_val_d = head_dec;
          head_ram_d = 1'b0;
        end
      end

      // Successful requests join the queue tail in minislot order.
      for (int k = 0; k < SLOT_PORTS; k++) begin
        if (k < SLOTS_USED) begin
          mine = req_flag_q && (own_slot_q == 2'(k + 1));
          if (item_q.slot_state[k] == SLOT_SUCCESS) begin
            if (tq_fill < CntW'(TqDepth)) begin
              bank_we[push_ptr[TQ_BANK_W-1:0]]    = 1'b1;
              bank_waddr[push_ptr[TQ_BANK_W-1:0]] = push_ptr[PtrW-1:TQ_BANK_W];
              bank_wdata[push_ptr[TQ_BANK_W-1:0]] = SizeBits'(item_q.slot_size[k]);
              if (!any_push) first_sz = SizeBits'(item_q.slot_size[k]);
              any_push = 1'b1;
              push_ptr = push_ptr + PtrW'(1);
              tq_fill  = tq_fill + CntW'(1);
              if (mine) begin
                own_succ     = 1'b1;
                own_tq_pos_d = tq_fill;
              end
            end else begin
              overflow = 1'b1;
              if (mine) begin
                own_succ = 1'b1;
                own_drop = 1'b1;
              end
            end
          end else if (item_q.slot_state[k] >= SLOT_COLLISION) begin
            ncoll = ncoll + 2'd1;
            if (mine) begin
              own_coll  = 1'b1;
              coll_rank = ncoll;
            end
          end
        end
      end
      if (own_drop) own_tq_pos_d = '0;
      tq_count_d = tq_fill;
      tail_ptr_d = push_ptr;

      // Pick up the new head count: fetch the next stored message after a pop, or take
      // the first appended message when the queue was empty or has just emptied.
      if (pop && (tq_count_q > CntW'(1))) begin
        bank_re[head_ptr_d[TQ_BANK_W-1:0]] = 1'b1;
        rd_row     = head_ptr_d[PtrW-1:TQ_BANK_W];
        head_ram_d = 1'b1;
      end else if ((pop || (tq_count_q == '0)) && any_push) begin
        head_val_d = first_sz;
        head_ram_d = 1'b0;
      end

      // Collision resolution queue: serve one, append the colliders.
      if (rq_count_q != 8'd0) rq_dec = rq_count_q - 8'd1;
      if (own_rq_pos_q != 8'd0) own_rq_pos_d = own_rq_pos_q - 8'd1;
      rq_sum = {1'b0, rq_dec} + 9'(ncoll);
      if (rq_sum > {1'b0, RQ_MAX}) begin
        rq_count_d = RQ_MAX;
        overflow   = 1'b1;
      end else begin
        rq_count_d = rq_sum[7:0];
      end
      if (own_coll && !own_succ) begin
        rq_pos = {1'b0, rq_dec} + 9'(coll_rank);
        if (rq_pos > {1'b0, RQ_MAX}) begin
          own_rq_pos_d = RQ_MAX;
          overflow     = 1'b1;
        end else begin
          own_rq_pos_d = rq_pos[7:0];
        end
      end

      req_flag_d = 1'b0;
      own_slot_d = 2'd0;
    end
  end

  // Packet-count banks: consecutive ring entries sit in consecutive banks.
  for (genvar b = 0; b < TQ_BANKS; b++) begin : g_bank
    dqsm_ram #(
      .Width (SizeBits),
      .Depth (1 << RowW)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (step && bank_we[b]),
      .waddr_i (bank_waddr[b]),
      .wdata_i (bank_wdata[b]),
      .re_i    (step && bank_re[b]),
      .raddr_i (rd_row),
      .rdata_o (bank_rdata[b])
    );
  end

  // Result packing, lowest field first.
  assign result = {overflow, own_rq_pos_d, own_tq_pos_d, rq_count_d, tq_count_d,
                   req_size, req_slot, send_request, send_data};

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      tq_count_q   <= '0;
      rq_count_q   <= 8'd0;
      own_tq_pos_q <= '0;
      own_rq_pos_q <= 8'd0;
      req_flag_q   <= 1'b0;
      own_slot_q   <= 2'd0;
      head_ptr_q   <= '0;
      tail_ptr_q   <= '0;
      head_val_q   <= '0;
      head_ram_q   <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        item_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= item_valid_q;
      end
      if (step) begin
        tq_count_q   <= tq_count_d;
        rq_count_q   <= rq_count_d;
        own_tq_pos_q <= own_tq_pos_d;
        own_rq_pos_q <= own_rq_pos_d;
        req_flag_q   <= req_flag_d;
        own_slot_q   <= own_slot_d;
        head_ptr_q   <= head_ptr_d;
        tail_ptr_q   <= tail_ptr_d;
        head_val_q   <= head_val_d;
        head_ram_q   <= head_ram_d;
      end
    end
  end

  // Payload: hold the input item and the result.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) item_q <= in_item;
    if (step) begin
      out_data_q <= OutDataW'(result);
    end
  end

endmodule

// Simple dual-port RAM with one write port and a registered read port.
module dqsm_ram #(
  parameter int  Width = 8,
  parameter int  Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

endmodule

>>> tb/distributed_queue_station_mac_unit_tb.sv
// Self-checking testbench: drives random and directed frame items and checks every result.
`timescale 1ns / 100ps

module distributed_queue_station_mac_unit_tb;
  import dqsm_pkg::*;

  localparam int RES_W       = 48;    // result tdata width at the default parameters
  localparam int STALL_LIMIT = 2000;  // cycles without any transaction before giving up
  localparam int HOLD_AT     = 250;   // result count at which the sink holds off for long
  localparam int HOLD_CYCLES = 150;
  localparam int NOTE_LIMIT  = 100;   // mismatch lines printed before going quiet

  // A slot code above collision; the block must count it as a collision.
  localparam logic [1:0] SLOT_JAMMED = 2'd3;

  typedef enum int {TRAFFIC_MIXED, TRAFFIC_FILL, TRAFFIC_CROWD, TRAFFIC_DRAIN} traffic_e;

  typedef struct packed {
    logic       send_data;
    logic       send_request;
    logic [1:0] request_slot;
    logic [7:0] request_size;
    logic [6:0] tq_length;
    logic [7:0] rq_length;
    logic [6:0] tq_position;
    logic [7:0] rq_position;
    logic       overflow;
  } mac_result_t;

  // Tracks the station's queue state, predicts each result and checks the block's output
  // against the oldest prediction.
  class station_tracker;
    mac_result_t due_results[$];
    int          tq_len = 0;
    int          rq_len = 0;
    int          own_tq = 0;
    int          own_rq = 0;
    logic [7:0]  pkt_left [TQ_DEPTH];
    int          head = 0;
    int          tail = 0;
    bit          sent_req = 1'b0;
    int          own_slot = 0;
    int          errors = 0;
    int          checked = 0;
    int          data_frames = 0;
    int          requests = 0;
    int          overflows = 0;
    int          peak_tq = 0;
    int          peak_rq = 0;

    function int outstanding();
      return due_results.size();
    endfunction

    function void predict_item(in_item_t it);
      mac_result_t r;
      int          ncoll;
      int          coll_rank;
      int          rq_base;
      int          pos;
      int          slot;
      bit          mine;
      bit          own_succ;
      bit          own_coll;
      bit          own_drop;
      logic [7:0]  left;
      r         = '0;
      ncoll     = 0;
      coll_rank = 0;
      own_succ  = 1'b0;
      own_coll  = 1'b0;
      own_drop  = 1'b0;
      if (it.req_type == REQ_FRAME_START) begin
        if (tq_len > 0 && own_tq == 1) r.send_data = 1'b1;
        if ((rq_len == 0 && own_tq == 0 && own_rq == 0 && it.has_message) ||
            (rq_len > 0 && own_rq == 1)) begin
          // Clamp the chosen minislot into the usable range.
          slot = int'(it.chosen_slot);
          if (slot < 1) slot = 1;
          if (slot > SLOTS_USED) slot = SLOTS_USED;
          r.send_request = 1'b1;
          r.request_slot = 2'(slot);
          r.request_size = it.message_size;
        end
        // A later frame start simply overwrites what an earlier one noted.
        sent_req = r.send_request;
        own_slot = int'(r.request_slot);
        data_frames += int'(r.send_data);
        requests    += int'(r.send_request);
      end else begin
        // Take one packet off the head message; retire it once nothing is left.
        if (tq_len > 0) begin
          left = pkt_left[head];
          if (left > 0) left--;
          pkt_left[head] = left;
          if (left == 0) begin
            tq_len--;
            if (own_tq > 0) own_tq--;
            head = (head + 1) % TQ_DEPTH;
          end
        end
        // Successful requests join the transmission queue in minislot order.
        for (int k = 0; k < SLOTS_USED; k++) begin
          mine = sent_req && own_slot == k + 1;
          if (it.slot_state[k] == SLOT_SUCCESS) begin
            if (tq_len < TQ_DEPTH) begin
              pkt_left[tail] = it.slot_size[k];
              tail = (tail + 1) % TQ_DEPTH;
              tq_len++;
              if (mine) begin
                own_succ = 1'b1;
                own_tq   = tq_len;
              end
            end else begin
              r.overflow = 1'b1;
              if (mine) begin
                own_succ = 1'b1;
                own_drop = 1'b1;
              end
            end
          end else if (it.slot_state[k] >= SLOT_COLLISION) begin
            ncoll++;
            if (mine) begin
              own_coll  = 1'b1;
              coll_rank = ncoll;
            end
          end
        end
        if (own_drop) own_tq = 0;
        // Advance the collision resolution queue, then append this frame's collisions.
        if (rq_len > 0) rq_len--;
        if (own_rq > 0) own_rq--;
        rq_base = rq_len;
        rq_len += ncoll;
        if (rq_len > int'(RQ_MAX)) begin
          rq_len     = int'(RQ_MAX);
          r.overflow = 1'b1;
        end
        if (own_coll && !own_succ) begin
          pos = rq_base + coll_rank;
          if (pos > int'(RQ_MAX)) begin
            pos        = int'(RQ_MAX);
            r.overflow = 1'b1;
          end
          own_rq = pos;
        end
        sent_req = 1'b0;
        own_slot = 0;
      end
      r.tq_length   = 7'(tq_len);
      r.rq_length   = 8'(rq_len);
      r.tq_position = 7'(own_tq);
      r.rq_position = 8'(own_rq);
      overflows += int'(r.overflow);
      if (tq_len > peak_tq) peak_tq = tq_len;
      if (rq_len > peak_rq) peak_rq = rq_len;
      due_results.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
      // Keep counting after the cap, but stop flooding the log.
      if (errors < NOTE_LIMIT)
        $display("result %0d: %s got %0d, want %0d", checked, what, got, want);
      errors++;
    endtask

    task check_result(logic [RES_W-1:0] data);
      mac_result_t got;
      mac_result_t want;
      got.send_data    = data[0];
      got.send_request = data[1];
      got.request_slot = data[3:2];
      got.request_size = data[11:4];
      got.tq_length    = data[18:12];
      got.rq_length    = data[26:19];
      got.tq_position  = data[33:27];
      got.rq_position  = data[41:34];
      got.overflow     = data[42];
      if (due_results.size() == 0) begin
        report_mismatch("result with nothing outstanding, tdata low bits",
                        int'(data[31:0]), 0);
      end else begin
        want = due_results.pop_front();
        if (got.send_data != want.send_data)
          report_mismatch("send_data", int'(got.send_data), int'(want.send_data));
        if (got.send_request != want.send_request)
          report_mismatch("send_request", int'(got.send_request), int'(want.send_request));
        if (got.request_slot != want.request_slot)
          report_mismatch("request_slot", int'(got.request_slot), int'(want.request_slot));
        if (got.request_size != want.request_size)
          report_mismatch("request_size", int'(got.request_size), int'(want.request_size));
        if (got.tq_length != want.tq_length)
          report_mismatch("tq_length", int'(got.tq_length), int'(want.tq_length));
        if (got.rq_length != want.rq_length)
          report_mismatch("rq_length", int'(got.rq_length), int'(want.rq_length));
        if (got.tq_position != want.tq_position)
          report_mismatch("tq_position", int'(got.tq_position), int'(want.tq_position));
        if (got.rq_position != want.rq_position)
          report_mismatch("rq_position", int'(got.rq_position), int'(want.rq_position));
        if (got.overflow != want.overflow)
          report_mismatch("overflow", int'(got.overflow), int'(want.overflow));
      end
      checked++;
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [RES_W-1:0]     m_axis_tdata;

  station_tracker board = new;
  bit             steady = 1'b0;   // set: neither side idles
  int             items_sent = 0;
  int             results_seen = 0;
  int             quiet_cycles = 0;

  distributed_queue_station_mac_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one item after a random gap, hold it until the block takes it, then predict.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = steady ? 0 : int'($urandom_range(0, 6));
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.req_type;
    // Pack the fields lowest first: has_message, message_size, chosen_slot, states, sizes.
    s_axis_tdata  <= {{(IN_DATA_W - 41){1'b0}},
                      it.slot_size[2], it.slot_size[1], it.slot_size[0],
                      it.slot_state[2], it.slot_state[1], it.slot_state[0],
                      it.chosen_slot, it.message_size, it.has_message};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.predict_item(it);
    items_sent++;
  endtask

  // Frame start item; the minislot fields carry random noise the block must ignore.
  function automatic in_item_t frame_start(logic has, logic [7:0] size, logic [1:0] chosen);
    in_item_t it;
    it.req_type     = REQ_FRAME_START;
    it.has_message  = has;
    it.message_size = size;
    it.chosen_slot  = chosen;
    for (int k = 0; k < SLOT_PORTS; k++) begin
      it.slot_state[k] = 2'($urandom_range(0, 3));
      it.slot_size[k]  = 8'($urandom_range(0, 255));
    end
    return it;
  endfunction

  // Feedback item; the request fields carry random noise the block must ignore.
  function automatic in_item_t feedback(logic [1:0] s1, logic [1:0] s2, logic [1:0] s3,
                                        logic [7:0] z1, logic [7:0] z2, logic [7:0] z3);
    in_item_t it;
    it.req_type      = REQ_FEEDBACK;
    it.has_message   = 1'($urandom_range(0, 1));
    it.message_size  = 8'($urandom_range(0, 255));
    it.chosen_slot   = 2'($urandom_range(0, 3));
    it.slot_state[0] = s1;
    it.slot_state[1] = s2;
    it.slot_state[2] = s3;
    it.slot_size[0]  = z1;
    it.slot_size[1]  = z2;
    it.slot_size[2]  = z3;
    return it;
  endfunction

  // Draw a minislot outcome weighted by the traffic mix; in mixed traffic favour success for our own request.
  function automatic logic [1:0] pick_outcome(traffic_e mode, bit own);
    int roll;
    roll = int'($urandom_range(0, 99));
    if (own && mode == TRAFFIC_MIXED && roll < 50) return SLOT_SUCCESS;
    roll = int'($urandom_range(0, 99));
    case (mode)
      TRAFFIC_FILL: begin
        if (roll < 10) return SLOT_EMPTY;
        if (roll < 85) return SLOT_SUCCESS;
        return SLOT_COLLISION;
      end
      TRAFFIC_CROWD: begin
        if (roll < 5) return SLOT_EMPTY;
        if (roll < 10) return SLOT_SUCCESS;
        if (roll < 85) return SLOT_COLLISION;
        return SLOT_JAMMED;
      end
      TRAFFIC_DRAIN: begin
        if (roll < 80) return SLOT_EMPTY;
        if (roll < 90) return SLOT_SUCCESS;
        return SLOT_COLLISION;
      end
      default: begin
        if (roll < 30) return SLOT_EMPTY;
        if (roll < 65) return SLOT_SUCCESS;
        if (roll < 95) return SLOT_COLLISION;
        return SLOT_JAMMED;
      end
    endcase
  endfunction

  function automatic in_item_t random_feedback(traffic_e mode);
    logic [1:0] st [3];
    logic [7:0] sz [3];
    bit         own;
    for (int k = 0; k < 3; k++) begin
      own   = board.sent_req && board.own_slot == k + 1;
      st[k] = pick_outcome(mode, own);
      // Keep queued messages short so the queue turns over; a rare one is full range.
      if (st[k] == SLOT_SUCCESS)
        sz[k] = ($urandom_range(0, 99) < 2) ? 8'($urandom_range(0, 255)) :
                                              8'($urandom_range(0, 3));
      else
        sz[k] = 8'($urandom_range(0, 255));
    end
    return feedback(st[0], st[1], st[2], sz[0], sz[1], sz[2]);
  endfunction

  // Mostly frame start then feedback pairs; the rest are lone items that break the pairing.
  task automatic run_traffic(traffic_e mode, int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 88) begin
        send_item(frame_start($urandom_range(0, 9) != 0, 8'($urandom_range(0, 255)),
                              2'($urandom_range(0, 3))));
        send_item(random_feedback(mode));
        sent += 2;
      end else if ($urandom_range(0, 1) != 0) begin
        send_item(random_feedback(mode));
        sent++;
      end else begin
        send_item(frame_start(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              2'($urandom_range(0, 3))));
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: feedback with no frame start before it.
    send_item(feedback(SLOT_EMPTY, SLOT_EMPTY, SLOT_EMPTY, 8'd0, 8'd0, 8'd0));
    send_item(frame_start(1'b0, 8'd0, 2'd1));
    // Chosen slot out of range clamps to the first; a repeated frame start overwrites it.
    send_item(frame_start(1'b1, 8'hFF, 2'd0));
    send_item(frame_start(1'b1, 8'h55, 2'd3));
    // Own request succeeds with a zero-packet message; the jammed code counts as collision.
    send_item(feedback(SLOT_COLLISION, SLOT_JAMMED, SLOT_SUCCESS, 8'hFF, 8'hFF, 8'd0));
    send_item(frame_start(1'b1, 8'h0F, 2'd2));
    send_item(feedback(SLOT_SUCCESS, SLOT_SUCCESS, SLOT_SUCCESS, 8'hFF, 8'd1, 8'd2));
    send_item(feedback(SLOT_EMPTY, SLOT_EMPTY, SLOT_EMPTY, 8'hAA, 8'h55, 8'hFF));
    // Own request collides and joins the collision resolution queue.
    send_item(frame_start(1'b1, 8'hAA, 2'd2));
    send_item(feedback(SLOT_COLLISION, SLOT_COLLISION, SLOT_EMPTY, 8'd0, 8'd0, 8'd0));
    send_item(frame_start(1'b1, 8'd0, 2'd1));
    send_item(feedback(SLOT_EMPTY, SLOT_EMPTY, SLOT_EMPTY, 8'd0, 8'd0, 8'd0));
    // Retry from the collision queue, then report our minislot empty: request lost.
    send_item(frame_start(1'b1, 8'h3C, 2'd1));
    send_item(feedback(SLOT_EMPTY, SLOT_EMPTY, SLOT_EMPTY, 8'd0, 8'd0, 8'd0));
    send_item(frame_start(1'b1, 8'd0, 2'd3));
    send_item(feedback(SLOT_JAMMED, SLOT_JAMMED, SLOT_JAMMED, 8'hFF, 8'hFF, 8'hFF));
    send_item(frame_start(1'b1, 8'hFF, 2'd3));
    send_item(feedback(SLOT_SUCCESS, SLOT_COLLISION, SLOT_SUCCESS, 8'h80, 8'h7F, 8'd1));

    run_traffic(TRAFFIC_MIXED, 420);

    // Drop valid and wait for every outstanding result before carrying on.
    s_axis_tvalid <= 1'b0;
    while (board.outstanding() > 0) @(posedge clk_i);

    // Back-to-back burst that fills the transmission queue into overflow.
    steady = 1'b1;
    run_traffic(TRAFFIC_FILL, 160);
    steady = 1'b0;
    // Collision-heavy traffic to saturate the collision resolution queue, then drain.
    run_traffic(TRAFFIC_CROWD, 320);
    run_traffic(TRAFFIC_DRAIN, 300);
    run_traffic(TRAFFIC_MIXED, 280);

    s_axis_tvalid <= 1'b0;
    while (board.outstanding() > 0) @(posedge clk_i);
    // Keep the clock running so any stray result can show up.
    repeat (10) @(posedge clk_i);

    $display("covered %0d items: %0d data frames, %0d requests, %0d overflow results",
             items_sent, board.data_frames, board.requests, board.overflows);
    $display("peak queue lengths: transmission %0d, collision resolution %0d",
             board.peak_tq, board.peak_rq);
    if (board.errors == 0) begin
      $display("distributed_queue_station_mac_unit regression: pass");
    end else begin
      $display("distributed_queue_station_mac_unit regression: fail");
    end
    $finish;
  end

  // Result sink: stall at random per transaction, with one long hold-off to back the block up.
  initial begin : result_sink
    int stall;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (results_seen == HOLD_AT) stall = HOLD_CYCLES;
      else stall = steady ? 0 : int'($urandom_range(0, 6));
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      board.check_result(m_axis_tdata);
      results_seen++;
    end
  end

  // Watchdog: end the run if no transaction moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d results outstanding", board.outstanding());
      $display("distributed_queue_station_mac_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
